// ===== design/lrupr_pkg.sv =====
// shared types and constants for the lru page replacement block
// no dependencies; used by every module of the block and by its checker
`default_nettype none

package lrupr_pkg;

    localparam int CFG_W   = 4;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 32;
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 3;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
    localparam logic [STAMP_W-1:0] STAMP_MAX    = 32'hFFFF_FFFF;
    localparam logic [FAULT_W-1:0] FAULT_MAX    = 32'hFFFF_FFFF;

    // result word layout, lowest bit first
    localparam int OUT_HIT_LSB  = 0;
    localparam int OUT_SLOT_LSB = 1;
    localparam int OUT_EVV_LSB  = 4;
    localparam int OUT_EVP_LSB  = 5;
    localparam int OUT_FLT_LSB  = 21;
    localparam int OUT_OVF_LSB  = 53;
    localparam int OUT_USED_W   = 54;
    localparam int OUT_W        = 56;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

// ===== design/lru_page_replacement.sv =====
// lru page replacement: a reference is taken in the idle state, the scan state
// then reads each managed frame over the single frame memory read port, and the write
// state stores the chosen frame, registers the result and raises m_tvalid,
// waiting while the output stalls; no reference is taken before the last is written
// reset: all frames empty, counters and overflow flag cleared, frames_in_use 8,
// no clearing pass; new_string empties the frames in the cycle it is taken
// uses lrupr_pkg and lrupr_frame_store
`default_nettype none

module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lrupr_pkg::PAGE_W-1:0]  s_tdata,  // page
    input  wire logic                          s_tuser,  // new_string
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit, slot, evicted_valid, evicted_page, fault_count, stamp_overflow
    output logic      [lrupr_pkg::OUT_W-1:0]   m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]   cfg_data   // frames_in_use
);

    localparam int FI = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int SW = (PAGE_BITS < lrupr_pkg::PAGE_W) ? PAGE_BITS : lrupr_pkg::PAGE_W;

    lrupr_pkg::state_t state_reg, state_next;

    logic [lrupr_pkg::CFG_W-1:0]   frames_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_w;
    logic [CW-1:0]                 idx_reg;
    logic [SW-1:0]                 page_reg;
    logic                          rd_pend_reg;
    logic [FI-1:0]                 eidx_reg;

    logic                          hit_found_reg;
    logic [FI-1:0]                 hit_pos_reg;
    logic                          emp_found_reg;
    logic [FI-1:0]                 emp_pos_reg;
    logic [lrupr_pkg::STAMP_W-1:0] min_stamp_reg;
    logic [FI-1:0]                 min_pos_reg;
    logic [SW-1:0]                 min_page_reg;

    logic [lrupr_pkg::STAMP_W-1:0] ref_reg;
    logic [lrupr_pkg::STAMP_W-1:0] ref_next;
    logic [lrupr_pkg::FAULT_W-1:0] fault_reg;
    logic [lrupr_pkg::FAULT_W-1:0] fault_next;
    logic                          ovf_reg;
    logic                          ovf_next;

    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [lrupr_pkg::SLOT_W-1:0]  out_slot_reg;
    logic                          out_evv_reg;
    logic [lrupr_pkg::PAGE_W-1:0]  out_evp_reg;
    logic [lrupr_pkg::FAULT_W-1:0] out_fault_reg;
    logic                          out_ovf_reg;

    logic                          in_xfer;
    logic                          out_free;
    logic                          issue;
    logic                          do_write;
    logic [FI-1:0]                 pos_w;
    logic                          evict_w;

    logic [lrupr_pkg::STAMP_W-1:0] rd_stamp;
    logic [SW-1:0]                 rd_page;
    logic                          rd_valid;

    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        if (frames_reg == '0)
        begin
            count_w = CW'(1);
        end
        else if (32'(frames_reg) > MAX_FRAMES)
        begin
            count_w = CW'(MAX_FRAMES);
        end
        else
        begin
            count_w = CW'(frames_reg);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = lrupr_pkg::ST_SCAN;
                end
            end
            lrupr_pkg::ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = lrupr_pkg::ST_WRITE;
                end
            end
            lrupr_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = lrupr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        do_write = 1'b0;
        case (state_reg)
            lrupr_pkg::ST_IDLE:  s_tready = 1'b1;
            lrupr_pkg::ST_SCAN:  issue    = (idx_reg < count_reg);
            lrupr_pkg::ST_WRITE: do_write = out_free;
            default:             s_tready = 1'b0;
        endcase
    end

    // victim choice: the hit frame, else the first empty, else the oldest stamp
    always_comb
    begin
        evict_w = 1'b0;
        if (hit_found_reg)
        begin
            pos_w = hit_pos_reg;
        end
        else if (emp_found_reg)
        begin
            pos_w = emp_pos_reg;
        end
        else
        begin
            pos_w   = min_pos_reg;
            evict_w = 1'b1;
        end
    end

    always_comb
    begin
        ref_next = (ref_reg < lrupr_pkg::STAMP_MAX) ? ref_reg + 1'b1 : ref_reg;
        ovf_next = ovf_reg || (ref_next == lrupr_pkg::STAMP_MAX);
        if (!hit_found_reg && (fault_reg < lrupr_pkg::FAULT_MAX))
        begin
            fault_next = fault_reg + 1'b1;
        end
        else
        begin
            fault_next = fault_reg;
        end
    end

    lrupr_frame_store #(
        .MAX_FRAMES (MAX_FRAMES),
        .SW         (SW),
        .FI         (FI)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_all  (in_xfer && s_tuser),
        .rd_en    (issue),
        .rd_idx   (idx_reg[FI-1:0]),
        .rd_stamp (rd_stamp),
        .rd_page  (rd_page),
        .rd_valid (rd_valid),
        .wr_en    (do_write),
        .wr_idx   (pos_w),
        .wr_stamp (ref_next),
        .wr_page  (page_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrupr_pkg::ST_IDLE;
            frames_reg    <= lrupr_pkg::FRAMES_RESET;
            ref_reg       <= '0;
            fault_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            emp_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
            if (cfg_valid && cfg_ready)
            begin
                frames_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                idx_reg       <= '0;
                hit_found_reg <= 1'b0;
                emp_found_reg <= 1'b0;
                if (s_tuser)
                begin
                    ref_reg   <= '0;
                    fault_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            // evaluate the entry read in the previous cycle
            if (rd_pend_reg)
            begin
                if (rd_valid && (rd_page == page_reg) && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!rd_valid && !emp_found_reg)
                begin
                    emp_found_reg <= 1'b1;
                end
            end
            if (do_write)
            begin
                ref_reg   <= ref_next;
                fault_reg <= fault_next;
                ovf_reg   <= ovf_next;
            end
            if (do_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            page_reg  <= s_tdata[SW-1:0];
            count_reg <= count_w;
        end
        if (issue)
        begin
            eidx_reg <= idx_reg[FI-1:0];
        end
        if (rd_pend_reg)
        begin
            if (rd_valid && (rd_page == page_reg) && !hit_found_reg)
            begin
                hit_pos_reg <= eidx_reg;
            end
            if (!rd_valid && !emp_found_reg)
            begin
                emp_pos_reg <= eidx_reg;
            end
            // strict compare keeps the lowest index on a tie
            if ((eidx_reg == '0) || (rd_stamp < min_stamp_reg))
            begin
                min_stamp_reg <= rd_stamp;
                min_pos_reg   <= eidx_reg;
                min_page_reg  <= rd_page;
            end
        end
        if (do_write)
        begin
            out_hit_reg   <= hit_found_reg;
            out_slot_reg  <= lrupr_pkg::SLOT_W'(pos_w);
            out_evv_reg   <= evict_w;
            out_evp_reg   <= evict_w ? lrupr_pkg::PAGE_W'(min_page_reg) : '0;
            out_fault_reg <= fault_next;
            out_ovf_reg   <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lrupr_pkg::OUT_W - lrupr_pkg::OUT_USED_W){1'b0}},
                       out_ovf_reg, out_fault_reg, out_evp_reg,
                       out_evv_reg, out_slot_reg, out_hit_reg};

endmodule

`default_nettype wire

// ===== design/lrupr_frame_store.sv =====
// frame table: page and stamp memory with a registered read,
// plus per-frame valid flops; uses lrupr_pkg
`default_nettype none

module lrupr_frame_store #(
    parameter int MAX_FRAMES = 8,
    parameter int SW         = 16,
    parameter int FI         = 3
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        clr_all,
    input  wire logic                        rd_en,
    input  wire logic [FI-1:0]               rd_idx,
    output logic      [lrupr_pkg::STAMP_W-1:0] rd_stamp,
    output logic      [SW-1:0]               rd_page,
    output logic                             rd_valid,
    input  wire logic                        wr_en,
    input  wire logic [FI-1:0]               wr_idx,
    input  wire logic [lrupr_pkg::STAMP_W-1:0] wr_stamp,
    input  wire logic [SW-1:0]               wr_page
);

    localparam int EW = lrupr_pkg::STAMP_W + SW;

    logic [EW-1:0]         mem [MAX_FRAMES];
    logic [EW-1:0]         rd_data_reg;
    logic                  rd_valid_reg;
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_stamp, wr_page};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr_all)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_stamp = rd_data_reg[EW-1:SW];
    assign rd_page  = rd_data_reg[SW-1:0];
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ===== design/lrupr_checker.sv =====
// port-level checks for lru_page_replacement, attached by bind
// uses lrupr_pkg for the result word layout
`default_nettype none

module lrupr_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [lrupr_pkg::OUT_W-1:0] m_tdata
);

    logic                                out_hit;
    logic                                out_evv;
    logic [lrupr_pkg::PAGE_W-1:0]        out_evp;
    logic [lrupr_pkg::FAULT_W-1:0]       out_fault;

    assign out_hit   = m_tdata[lrupr_pkg::OUT_HIT_LSB];
    assign out_evv   = m_tdata[lrupr_pkg::OUT_EVV_LSB];
    assign out_evp   = m_tdata[lrupr_pkg::OUT_EVP_LSB +: lrupr_pkg::PAGE_W];
    assign out_fault = m_tdata[lrupr_pkg::OUT_FLT_LSB +: lrupr_pkg::FAULT_W];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second reference taken while one is in work");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_hit && out_evv))
        else $error("hit reported together with an eviction");

    a_evp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !out_evv |-> out_evp == '0)
        else $error("evicted page nonzero without an eviction");

    a_hit_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_hit |-> out_fault != '0)
        else $error("hit with no fault since the string began");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// stream testbench for lru_page_replacement: directed and random page references
// are checked against an in-bench lru predictor; depends on lrupr_pkg and the rtl
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFRAMES        = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_PAUSE      = 30;

    typedef struct packed {
        logic                          ovf;
        logic [lrupr_pkg::FAULT_W-1:0] flt;
        logic [lrupr_pkg::PAGE_W-1:0]  evp;
        logic                          evv;
        logic [lrupr_pkg::SLOT_W-1:0]  slot;
        logic                          hit;
    } lru_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [lrupr_pkg::PAGE_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [lrupr_pkg::OUT_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [lrupr_pkg::CFG_W-1:0] cfg_data;

    always #5 clk = ~clk;

    lru_page_replacement #(
        .MAX_FRAMES (NFRAMES),
        .PAGE_BITS  (lrupr_pkg::PAGE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // page
        .s_tuser   (s_tuser),   // new_string
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // hit, slot, evicted_valid, evicted_page, fault_count, overflow
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)   // frames_in_use
    );

    // lru predictor state
    logic [lrupr_pkg::PAGE_W-1:0]  page_tab [NFRAMES];
    bit                            occupied [NFRAMES];
    logic [lrupr_pkg::STAMP_W-1:0] stamp_tab[NFRAMES] = '{default: '0};
    logic [lrupr_pkg::STAMP_W-1:0] ref_cnt   = '0;
    logic [lrupr_pkg::FAULT_W-1:0] fault_cnt = '0;
    logic                          ovf_flag  = 1'b0;
    logic [lrupr_pkg::CFG_W-1:0]   frames_cfg = lrupr_pkg::FRAMES_RESET;

    lru_result_t pending_results[$];
    int err_cnt = 0;
    int burst_left = 1;
    int idle_cycles = 0;

    initial begin
        for (int j = 0; j < NFRAMES; j++) begin
            occupied[j] = 1'b0;
            page_tab[j] = '0;
        end
    end

    function automatic lru_result_t lru_access(input logic [lrupr_pkg::PAGE_W-1:0] pg,
                                               input logic ns);
        lru_result_t r;
        int n;
        int pos;
        bit found;
        logic [lrupr_pkg::STAMP_W-1:0] least;
        r = '0;
        found = 1'b0;
        pos = 0;
        if (ns) begin
            for (int j = 0; j < NFRAMES; j++) begin
                occupied[j] = 1'b0;
                page_tab[j] = '0;
                stamp_tab[j] = '0;
            end
            ref_cnt = '0;
            fault_cnt = '0;
            ovf_flag = 1'b0;
        end
        n = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : int'(frames_cfg);
        for (int j = 0; j < n; j++) begin
            if (!found && occupied[j] && page_tab[j] == pg) begin
                found = 1'b1;
                pos = j;
            end
        end
        if (found) begin
            r.hit = 1'b1;
        end else begin
            for (int j = 0; j < n; j++) begin
                if (!found && !occupied[j]) begin
                    found = 1'b1;
                    pos = j;
                end
            end
            if (!found) begin
                // every managed frame full: replace the oldest stamp, lowest index on a tie
                least = stamp_tab[0];
                pos = 0;
                for (int j = 1; j < n; j++) begin
                    if (stamp_tab[j] < least) begin
                        least = stamp_tab[j];
                        pos = j;
                    end
                end
                r.evv = 1'b1;
                r.evp = page_tab[pos];
            end
            page_tab[pos] = pg;
            occupied[pos] = 1'b1;
            if (fault_cnt != lrupr_pkg::FAULT_MAX) fault_cnt++;
        end
        if (ref_cnt != lrupr_pkg::STAMP_MAX) ref_cnt++;
        if (ref_cnt == lrupr_pkg::STAMP_MAX) ovf_flag = 1'b1;
        stamp_tab[pos] = ref_cnt;
        r.slot = pos[lrupr_pkg::SLOT_W-1:0];
        r.flt = fault_cnt;
        r.ovf = ovf_flag;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
            err_cnt++;
        end
    endfunction

    // result checker
    always @(posedge clk) begin
        lru_result_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                check_field("hit", 32'(e.hit), 32'(m_tdata[lrupr_pkg::OUT_HIT_LSB]));
                check_field("slot", 32'(e.slot),
                            32'(m_tdata[lrupr_pkg::OUT_SLOT_LSB +: lrupr_pkg::SLOT_W]));
                check_field("evicted_valid", 32'(e.evv),
                            32'(m_tdata[lrupr_pkg::OUT_EVV_LSB]));
                check_field("evicted_page", 32'(e.evp),
                            32'(m_tdata[lrupr_pkg::OUT_EVP_LSB +: lrupr_pkg::PAGE_W]));
                check_field("fault_count", e.flt,
                            m_tdata[lrupr_pkg::OUT_FLT_LSB +: lrupr_pkg::FAULT_W]);
                check_field("stamp_overflow", 32'(e.ovf),
                            32'(m_tdata[lrupr_pkg::OUT_OVF_LSB]));
            end
        end
    end

    // receiver stalls in modes: always ready, coin flip, mostly stalled
    int rx_mode = 0;
    int rx_left = 0;
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer, or later when a burst ends
    task automatic send_ref(input logic [lrupr_pkg::PAGE_W-1:0] pg, input logic ns);
        s_tvalid <= 1'b1;
        s_tdata <= pg;
        s_tuser <= ns;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(lru_access(pg, ns));
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // stop sending and wait for every expected result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        frames_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_fill_and_evict();
        write_frames(4'd8);
        send_ref(16'h0000, 1'b1);
        for (int p = 1; p < NFRAMES; p++) send_ref(lrupr_pkg::PAGE_W'(p), 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0003, 1'b0);
        send_ref(16'h8000, 1'b0);
        send_ref(16'h5555, 1'b0);
        // new string while frames are full
        send_ref(16'hFFFF, 1'b1);
        send_ref(16'hAAAA, 1'b0);
    endtask

    task automatic test_frame_limits();
        // zero behaves as one frame
        write_frames(4'd0);
        send_ref(16'h1234, 1'b1);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h4321, 1'b0);
        // above the built count behaves as all frames
        write_frames(4'd15);
        send_ref(16'h1234, 1'b0);
        send_ref(16'h4321, 1'b0);
    endtask

    task automatic test_count_change_mid_string();
        write_frames(4'd8);
        send_ref(16'h000A, 1'b1);
        send_ref(16'h000B, 1'b0);
        send_ref(16'h000C, 1'b0);
        send_ref(16'h000D, 1'b0);
        // frames past the new count are kept but not searched
        write_frames(4'd2);
        send_ref(16'h000C, 1'b0);
        send_ref(16'h000D, 1'b0);
        write_frames(4'd8);
        send_ref(16'h000C, 1'b0);
        send_ref(16'h000D, 1'b0);
    endtask

    task automatic test_random_strings();
        logic [lrupr_pkg::CFG_W-1:0] settings[12] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd5,
                                                     4'd9, 4'd2, 4'd7, 4'd4, 4'd6, 4'd8};
        logic [lrupr_pkg::PAGE_W-1:0] base;
        logic [lrupr_pkg::PAGE_W-1:0] pg;
        int span;
        int sel;
        logic ns;
        foreach (settings[k]) begin
            write_frames(settings[k]);
            base = lrupr_pkg::PAGE_W'($urandom);
            span = $urandom_range(1, 2 * NFRAMES + 2);
            for (int i = 0; i < 120; i++) begin
                if (i == 60) settle();
                ns = (i == 0 && $urandom_range(0, 1)) || ($urandom_range(0, 39) == 0);
                if (ns) begin
                    base = lrupr_pkg::PAGE_W'($urandom);
                    span = $urandom_range(1, 2 * NFRAMES + 2);
                end
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    pg = base + lrupr_pkg::PAGE_W'($urandom_range(0, span - 1));
                else if (sel < 92)
                    pg = lrupr_pkg::PAGE_W'($urandom);
                else if (sel < 96)
                    pg = 16'hFFFF;
                else
                    pg = 16'h0000;
                send_ref(pg, ns);
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_evict();
        test_frame_limits();
        test_count_change_mid_string();
        test_random_strings();

        settle();
        repeat (END_PAUSE) @(negedge clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_results.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
